// ----- hdl/pfm_pkg.sv -----
package pfm_pkg;

    localparam int CMD_W      = 2;
    localparam int CH_W       = 3;
    localparam int SMP_IN_W   = 16;
    localparam int HZ_W       = 32;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 30;
    localparam int MASK_W     = 6;
    localparam int CLK_W      = 30;
    localparam int CPW_W      = 17;
    localparam int GATE_W     = 16;
    localparam int MAXW_W     = 16;
    localparam int PEND_W     = 16;
    localparam int COMM_W     = 32;
    localparam int PROD_W     = COMM_W + CPW_W;
    localparam int DVD_W      = 36;
    localparam int DVS_W      = PROD_W + 1;

    localparam int LOW_RATE_LIMIT = 3;
    localparam int MS_PER_SEC     = 1000;
    localparam int SEC_PER_MIN    = 60;
    localparam int MS_PER_MIN     = MS_PER_SEC * SEC_PER_MIN;

    localparam logic [CMD_W-1:0] CMD_WRAP     = 2'd0;
    localparam logic [CMD_W-1:0] CMD_CAPTURE  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_GATE_END = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_MODE_MASK = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CLOCK_HZ  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CPW       = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_GATE_MS   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_WRAPS = 3'd4;

    localparam logic [CLK_W-1:0]  CLOCK_HZ_RESET  = 30'd1000000;
    localparam logic [CPW_W-1:0]  CPW_RESET       = 17'd65536;
    localparam logic [GATE_W-1:0] GATE_MS_RESET   = 16'd1000;
    localparam logic [MAXW_W-1:0] MAX_WRAPS_RESET = 16'd255;

    typedef enum logic [3:0] {
        S_IDLE,
        S_READ,
        S_MUL,
        S_PREP,
        S_DIV1_GO,
        S_DIV1_WAIT,
        S_DIV2_GO,
        S_DIV2_WAIT,
        S_DONE
    } pfm_state_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

    function automatic logic [HZ_W-1:0] sat32(input logic [DVD_W-1:0] v);
        logic [HZ_W-1:0] r;
        r = (|v[DVD_W-1:HZ_W]) ? '1 : v[HZ_W-1:0];
        return r;
    endfunction

endpackage

// ----- hdl/pfm_evt_if.sv -----
interface pfm_evt_if;
    logic                          valid;
    logic                          ready;
    logic [pfm_pkg::CMD_W-1:0]     cmd;
    logic [pfm_pkg::CH_W-1:0]      channel;
    logic [pfm_pkg::SMP_IN_W-1:0]  sample;

    modport source (output valid, output cmd, output channel, output sample, input ready);
    modport sink   (input valid, input cmd, input channel, input sample, output ready);
endinterface

// ----- hdl/pfm_res_if.sv -----
interface pfm_res_if;
    logic                      valid;
    logic                      ready;
    logic [pfm_pkg::CH_W-1:0]  out_channel;
    logic [pfm_pkg::HZ_W-1:0]  freq_hz;
    logic [pfm_pkg::HZ_W-1:0]  per_minute;
    logic                      no_signal;
    logic                      ignored;

    modport source (output valid, output out_channel, output freq_hz, output per_minute,
                    output no_signal, output ignored, input ready);
    modport sink   (input valid, input out_channel, input freq_hz, input per_minute,
                    input no_signal, input ignored, output ready);
endinterface

// ----- hdl/pulse_frequency_meter_core.sv -----
// Multi-channel pulse frequency meter.
// Event channel (evt): cmd, channel, sample; a transfer happens when valid and
// ready are both high. Result channel (res): one result per event with the
// channel, freq_hz, per_minute, no_signal and ignored.
// Configuration: cfg_we writes cfg_data to register cfg_index;
// write only while no event is in flight.
// Per-channel state sits in a single-port memory with a registered read;
// each in-range event reads its entry, updates it, writes it back, then computes the
// report on a shared radix-2 divider (36 steps per division, two divisions).
// An out-of-range channel goes straight to its result without a memory access,
// and a zero divisor skips both divisions. One event is processed at a
// time: a new event is taken only once the last has reached the result register.
// The result register frees the core: a new event is taken while a result
// waits for res.ready; a finished result then waits in the core for the slot.
// Reset clears all channel state to zero (per-entry valid bits) and loads the
// register defaults; no clearing pass is needed.
module pulse_frequency_meter_core #(
    parameter int CHANNELS     = 6,
    parameter int COUNTER_BITS = 16
) (
    input  logic                            clk,
    input  logic                            rst_n,
    pfm_evt_if.sink                         evt,
    pfm_res_if.source                       res,
    input  logic                            cfg_we,
    input  logic [pfm_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [pfm_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import pfm_pkg::*;

    localparam int SMP_W = (COUNTER_BITS < SMP_IN_W) ? COUNTER_BITS : SMP_IN_W;
    localparam int AW    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int ENT_W = PEND_W + COMM_W + SMP_W;
    localparam logic [31:0] CH_LIMIT = 32'(CHANNELS);

    logic [MASK_W-1:0] mode_mask_reg;
    logic [CLK_W-1:0]  clock_hz_reg;
    logic [CPW_W-1:0]  cpw_reg;
    logic [GATE_W-1:0] gate_ms_reg;
    logic [MAXW_W-1:0] max_wraps_reg;

    pfm_state_t state_reg;
    pfm_state_t state_next;

    logic [ENT_W-1:0]    mem [CHANNELS];
    logic [CHANNELS-1:0] valid_reg;

    logic [CMD_W-1:0]  cmd_reg;
    logic [CH_W-1:0]   ch_reg;
    logic [SMP_W-1:0]  smp_reg;
    logic              gated_reg;
    logic              ign_reg;
    logic [ENT_W-1:0]  rd_data_reg;
    logic              rd_valid_reg;
    logic [PEND_W-1:0] pend_reg;
    logic [COMM_W-1:0] comm_reg;
    logic [SMP_W-1:0]  last_reg;
    logic [PROD_W-1:0] prod_reg;
    logic [DVD_W-1:0]  num_hz_reg;
    logic [DVD_W-1:0]  num_pm_reg;
    logic [DVS_W-1:0]  dvs_hz_reg;
    logic [DVS_W-1:0]  dvs_pm_reg;
    logic [HZ_W-1:0]   hz_reg;
    logic [HZ_W-1:0]   pm_reg;
    logic              nosig_reg;

    logic              out_valid_reg;
    logic [CH_W-1:0]   out_ch_reg;
    logic [HZ_W-1:0]   out_hz_reg;
    logic [HZ_W-1:0]   out_pm_reg;
    logic              out_nosig_reg;
    logic              out_ign_reg;

    logic              acc;
    logic              in_range;
    logic              gated_in;
    logic [AW+CH_W-1:0] rd_ext;
    logic [AW+CH_W-1:0] wr_ext;
    logic [AW-1:0]     rd_addr;
    logic [AW-1:0]     wr_addr;
    logic [7:0]        mask_ext;

    logic              mem_we;
    logic              div_start;
    logic              load_out;

    logic [PEND_W-1:0] cur_p;
    logic [COMM_W-1:0] cur_c;
    logic [SMP_W-1:0]  cur_l;
    logic [PEND_W-1:0] new_p;
    logic [COMM_W-1:0] new_c;
    logic [SMP_W-1:0]  new_l;
    logic              new_ign;
    logic [COMM_W:0]   c_sum;

    logic [COMM_W-1:0] mul_a;
    logic [CPW_W-1:0]  mul_b;
    logic [DVS_W-1:0]  ticks;

    logic [DVD_W-1:0]  div_dvd;
    logic [DVS_W-1:0]  div_dvs;
    logic [DVD_W-1:0]  div_q;
    div_stat_t         div_stat;

    // Configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_mask_reg <= '0;
            clock_hz_reg  <= CLOCK_HZ_RESET;
            cpw_reg       <= CPW_RESET;
            gate_ms_reg   <= GATE_MS_RESET;
            max_wraps_reg <= MAX_WRAPS_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_MODE_MASK: mode_mask_reg <= cfg_data[MASK_W-1:0];
                CFG_CLOCK_HZ:  clock_hz_reg  <= cfg_data[CLK_W-1:0];
                CFG_CPW:       cpw_reg       <= cfg_data[CPW_W-1:0];
                CFG_GATE_MS:   gate_ms_reg   <= cfg_data[GATE_W-1:0];
                CFG_MAX_WRAPS: max_wraps_reg <= cfg_data[MAXW_W-1:0];
                default:       ;
            endcase
        end
    end

    assign acc      = evt.valid && evt.ready;
    assign in_range = (32'(evt.channel) < CH_LIMIT);
    assign mask_ext = {{(8 - MASK_W){1'b0}}, mode_mask_reg};
    assign gated_in = mask_ext[evt.channel];
    assign rd_ext   = {{AW{1'b0}}, evt.channel};
    assign wr_ext   = {{AW{1'b0}}, ch_reg};
    assign rd_addr  = rd_ext[AW-1:0];
    assign wr_addr  = wr_ext[AW-1:0];

    // Control FSM
    always_comb
    begin
        state_next = state_reg;
        evt.ready  = 1'b0;
        mem_we     = 1'b0;
        div_start  = 1'b0;
        load_out   = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                evt.ready = 1'b1;
                if (evt.valid)
                begin
                    state_next = in_range ? S_READ : S_DONE;
                end
            end
            S_READ:
            begin
                mem_we     = 1'b1;
                state_next = S_MUL;
            end
            S_MUL:
            begin
                state_next = S_PREP;
            end
            S_PREP:
            begin
                state_next = S_DIV1_GO;
                if (gated_reg ? (gate_ms_reg == '0) : (ticks == '0))
                begin
                    state_next = S_DONE;
                end
            end
            S_DIV1_GO:
            begin
                div_start  = 1'b1;
                state_next = S_DIV1_WAIT;
            end
            S_DIV1_WAIT:
            begin
                if (div_stat.done)
                begin
                    state_next = S_DIV2_GO;
                end
            end
            S_DIV2_GO:
            begin
                div_start  = 1'b1;
                state_next = S_DIV2_WAIT;
            end
            S_DIV2_WAIT:
            begin
                if (div_stat.done)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (!out_valid_reg || res.ready)
                begin
                    load_out   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Channel state memory
    always_ff @(posedge clk)
    begin
        if (acc && in_range)
        begin
            rd_data_reg  <= mem[rd_addr];
            rd_valid_reg <= valid_reg[rd_addr];
        end
        if (mem_we)
        begin
            mem[wr_addr] <= {new_p, new_c, new_l};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (mem_we)
        begin
            valid_reg[wr_addr] <= 1'b1;
        end
    end

    // Read-modify-write of the channel entry
    always_comb
    begin
        cur_p   = rd_valid_reg ? rd_data_reg[ENT_W-1 -: PEND_W] : '0;
        cur_c   = rd_valid_reg ? rd_data_reg[SMP_W +: COMM_W] : '0;
        cur_l   = rd_valid_reg ? rd_data_reg[SMP_W-1:0] : '0;
        new_p   = cur_p;
        new_c   = cur_c;
        new_l   = cur_l;
        new_ign = 1'b0;
        c_sum   = {1'b0, cur_c} + (COMM_W + 1)'(smp_reg);
        if (!gated_reg && (cmd_reg == CMD_WRAP))
        begin
            if (cur_p < max_wraps_reg)
            begin
                new_p = cur_p + PEND_W'(1);
            end
            if (COMM_W'(new_p) > cur_c)
            begin
                new_c = COMM_W'(new_p);
                new_l = '0;
            end
        end
        else if (!gated_reg && (cmd_reg == CMD_CAPTURE))
        begin
            new_l = smp_reg;
            new_c = COMM_W'(cur_p);
            new_p = '0;
        end
        else if (gated_reg && (cmd_reg == CMD_GATE_END))
        begin
            new_l = smp_reg;
            if (smp_reg < SMP_W'(LOW_RATE_LIMIT))
            begin
                new_c = c_sum[COMM_W] ? '1 : c_sum[COMM_W-1:0];
                if (cur_p != '1)
                begin
                    new_p = cur_p + PEND_W'(1);
                end
            end
            else
            begin
                new_c = '0;
                new_p = '0;
            end
        end
        else
        begin
            new_ign = 1'b1;
        end
    end

    // Divisor and dividend preparation
    assign mul_a = gated_reg ? COMM_W'(gate_ms_reg) : comm_reg;
    assign mul_b = gated_reg ? CPW_W'(pend_reg - PEND_W'(1)) : cpw_reg;
    assign ticks = DVS_W'(prod_reg) + DVS_W'(last_reg);

    assign div_dvd = (state_reg == S_DIV2_GO) ? num_pm_reg : num_hz_reg;
    assign div_dvs = (state_reg == S_DIV2_GO) ? dvs_pm_reg : dvs_hz_reg;

    pfm_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dvd),
        .divisor  (div_dvs),
        .quotient (div_q),
        .stat     (div_stat)
    );

    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                if (acc)
                begin
                    cmd_reg   <= evt.cmd;
                    ch_reg    <= evt.channel;
                    smp_reg   <= evt.sample[SMP_W-1:0];
                    gated_reg <= gated_in;
                    ign_reg   <= 1'b1;
                    hz_reg    <= '0;
                    pm_reg    <= '0;
                    nosig_reg <= 1'b0;
                end
            end
            S_READ:
            begin
                pend_reg <= new_p;
                comm_reg <= new_c;
                last_reg <= new_l;
                ign_reg  <= new_ign;
            end
            S_MUL:
            begin
                prod_reg <= PROD_W'(mul_a) * PROD_W'(mul_b);
                if (gated_reg)
                begin
                    num_hz_reg <= DVD_W'(last_reg) * DVD_W'(MS_PER_SEC);
                    num_pm_reg <= DVD_W'(last_reg) * DVD_W'(MS_PER_MIN);
                end
                else
                begin
                    num_hz_reg <= DVD_W'(clock_hz_reg);
                    num_pm_reg <= DVD_W'(clock_hz_reg) * DVD_W'(SEC_PER_MIN);
                end
            end
            S_PREP:
            begin
                if (gated_reg)
                begin
                    dvs_hz_reg <= DVS_W'(gate_ms_reg);
                    dvs_pm_reg <= (pend_reg > PEND_W'(1)) ? DVS_W'(prod_reg)
                                                          : DVS_W'(gate_ms_reg);
                    nosig_reg  <= (gate_ms_reg == '0);
                end
                else
                begin
                    dvs_hz_reg <= ticks;
                    dvs_pm_reg <= ticks;
                    nosig_reg  <= (ticks == '0);
                end
            end
            S_DIV1_WAIT:
            begin
                if (div_stat.done)
                begin
                    hz_reg <= sat32(div_q);
                end
            end
            S_DIV2_WAIT:
            begin
                if (div_stat.done)
                begin
                    pm_reg <= sat32(div_q);
                end
            end
            default:
            begin
            end
        endcase
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (load_out)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (res.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            out_ch_reg    <= ch_reg;
            out_hz_reg    <= hz_reg;
            out_pm_reg    <= pm_reg;
            out_nosig_reg <= nosig_reg;
            out_ign_reg   <= ign_reg;
        end
    end

    assign res.valid       = out_valid_reg;
    assign res.out_channel = out_ch_reg;
    assign res.freq_hz     = out_hz_reg;
    assign res.per_minute  = out_pm_reg;
    assign res.no_signal   = out_nosig_reg;
    assign res.ignored     = out_ign_reg;

`ifndef ASSERT_OFF
    a_wb_follows_transfer: assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |-> $past(evt.valid && evt.ready))
        else $error("entry write-back without a preceding event transfer");

    a_div_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        div_start |-> !div_stat.busy)
        else $error("divider started while busy");

    a_nosig_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (res.valid && res.no_signal) |-> (res.freq_hz == '0 && res.per_minute == '0))
        else $error("no_signal result with nonzero values");

    a_range_ignored: assert property (@(posedge clk) disable iff (!rst_n)
        (res.valid && (32'(res.out_channel) >= CH_LIMIT))
            |-> (res.ignored && !res.no_signal && res.freq_hz == '0))
        else $error("out-of-range channel result not ignored");
`endif

endmodule

// ----- hdl/pfm_div.sv -----
module pfm_div (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [pfm_pkg::DVD_W-1:0]  dividend,
    input  logic [pfm_pkg::DVS_W-1:0]  divisor,
    output logic [pfm_pkg::DVD_W-1:0]  quotient,
    output pfm_pkg::div_stat_t         stat
);
    import pfm_pkg::*;

    localparam int CNT_W = $clog2(DVD_W + 1);

    logic             busy_reg;
    logic             done_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [DVD_W-1:0] dvd_reg;
    logic [DVD_W-1:0] dvd_next;
    logic [DVS_W-1:0] dvs_reg;
    logic [DVS_W-1:0] rem_reg;
    logic [DVS_W-1:0] rem_next;
    logic [DVS_W:0]   rem_ext;
    logic [DVS_W:0]   rem_sub;
    logic             ge;

    always_comb
    begin
        rem_ext  = {rem_reg, dvd_reg[DVD_W-1]};
        ge       = (rem_ext >= {1'b0, dvs_reg});
        rem_sub  = rem_ext - {1'b0, dvs_reg};
        rem_next = ge ? rem_sub[DVS_W-1:0] : rem_ext[DVS_W-1:0];
        dvd_next = {dvd_reg[DVD_W-2:0], ge};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(DVD_W);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - CNT_W'(1);
                if (cnt_reg == CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            dvd_reg <= dividend;
            dvs_reg <= divisor;
            rem_reg <= '0;
        end
        else if (busy_reg)
        begin
            dvd_reg <= dvd_next;
            rem_reg <= rem_next;
        end
    end

    assign quotient  = dvd_reg;
    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

endmodule

// ----- tb/tb_top.sv -----
`timescale 1ns / 100ps

module tb_top;
    import pfm_pkg::*;

    localparam int NUM_CH        = 6;
    localparam int IDLE_PCT      = 35;
    localparam int SETTLE_CYCLES = 100;
    localparam int STALL_LIMIT   = 4000;
    localparam int MAX_REPORTS   = 10;

    localparam logic [CMD_W-1:0]     CMD_UNUSED      = 2'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_FIRST = 3'd5;

    typedef struct {
        logic [CH_W-1:0] chan;
        logic [HZ_W-1:0] hz;
        logic [HZ_W-1:0] rpm;
        logic            nosig;
        logic            ign;
    } meter_reading_t;

    class meter_scoreboard;
        logic [MASK_W-1:0]   mode_mask;
        logic [CLK_W-1:0]    clock_hz;
        logic [CPW_W-1:0]    ticks_per_wrap;
        logic [GATE_W-1:0]   gate_ms;
        logic [MAXW_W-1:0]   wrap_limit;
        logic [PEND_W-1:0]   open_wraps[NUM_CH];
        logic [COMM_W-1:0]   closed_wraps[NUM_CH];
        logic [SMP_IN_W-1:0] held_count[NUM_CH];
        meter_reading_t      readings_due[$];
        int faults;
        int n_wrap;
        int n_capture;
        int n_gate;
        int n_ignored;
        int n_outside;
        int n_nosig;
        int n_clipped;

        function new();
            mode_mask      = '0;
            clock_hz       = CLOCK_HZ_RESET;
            ticks_per_wrap = CPW_RESET;
            gate_ms        = GATE_MS_RESET;
            wrap_limit     = MAX_WRAPS_RESET;
            foreach (open_wraps[c])
            begin
                open_wraps[c]   = '0;
                closed_wraps[c] = '0;
                held_count[c]   = '0;
            end
            faults    = 0;
            n_wrap    = 0;
            n_capture = 0;
            n_gate    = 0;
            n_ignored = 0;
            n_outside = 0;
            n_nosig   = 0;
            n_clipped = 0;
        endfunction

        function logic [HZ_W-1:0] clip32(logic [63:0] v);
            return (v[63:HZ_W] != '0) ? '1 : v[HZ_W-1:0];
        endfunction

        function void apply_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_MODE_MASK: mode_mask      = data[MASK_W-1:0];
                CFG_CLOCK_HZ:  clock_hz       = data[CLK_W-1:0];
                CFG_CPW:       ticks_per_wrap = data[CPW_W-1:0];
                CFG_GATE_MS:   gate_ms        = data[GATE_W-1:0];
                CFG_MAX_WRAPS: wrap_limit     = data[MAXW_W-1:0];
                default: ;
            endcase
        endfunction

        function void note_event(logic [CMD_W-1:0] cmd, logic [CH_W-1:0] ch,
                                 logic [SMP_IN_W-1:0] smp);
            meter_reading_t r;
            logic           gated;
            logic [COMM_W:0] sum;
            logic [63:0]    ticks;
            logic [63:0]    pm;
            r.chan  = ch;
            r.hz    = '0;
            r.rpm   = '0;
            r.nosig = 1'b0;
            r.ign   = 1'b0;
            pm      = '0;
            if (ch >= NUM_CH)
            begin
                r.ign = 1'b1;
                n_outside++;
                n_ignored++;
                readings_due.push_back(r);
                return;
            end
            gated = mode_mask[ch];
            if (!gated && cmd == CMD_WRAP)
            begin
                n_wrap++;
                if (open_wraps[ch] < wrap_limit)
                    open_wraps[ch]++;
                if (COMM_W'(open_wraps[ch]) > closed_wraps[ch])
                begin
                    closed_wraps[ch] = COMM_W'(open_wraps[ch]);
                    held_count[ch]   = '0;
                end
            end
            else if (!gated && cmd == CMD_CAPTURE)
            begin
                n_capture++;
                held_count[ch]   = smp;
                closed_wraps[ch] = COMM_W'(open_wraps[ch]);
                open_wraps[ch]   = '0;
            end
            else if (gated && cmd == CMD_GATE_END)
            begin
                n_gate++;
                held_count[ch] = smp;
                if (smp < LOW_RATE_LIMIT)
                begin
                    sum = {1'b0, closed_wraps[ch]} + (COMM_W+1)'(smp);
                    closed_wraps[ch] = sum[COMM_W] ? '1 : sum[COMM_W-1:0];
                    if (open_wraps[ch] != '1)
                        open_wraps[ch]++;
                end
                else
                begin
                    closed_wraps[ch] = '0;
                    open_wraps[ch]   = '0;
                end
            end
            else
            begin
                r.ign = 1'b1;
                n_ignored++;
            end

            if (!gated)
            begin
                ticks = 64'(closed_wraps[ch]) * 64'(ticks_per_wrap) + 64'(held_count[ch]);
                if (ticks == 0)
                    r.nosig = 1'b1;
                else
                begin
                    r.hz  = clip32(64'(clock_hz) / ticks);
                    pm    = 64'(clock_hz) * 64'(SEC_PER_MIN) / ticks;
                    r.rpm = clip32(pm);
                end
            end
            else if (gate_ms == 0)
                r.nosig = 1'b1;
            else
            begin
                r.hz = clip32(64'(held_count[ch]) * 64'(MS_PER_SEC) / 64'(gate_ms));
                pm   = 64'(held_count[ch]) * 64'(MS_PER_MIN) / 64'(gate_ms);
                if (open_wraps[ch] > 1)
                    pm = pm / 64'(open_wraps[ch] - 1'b1);
                r.rpm = clip32(pm);
            end
            if (pm[63:HZ_W] != '0)
                n_clipped++;
            if (r.nosig)
                n_nosig++;
            readings_due.push_back(r);
        endfunction

        function void check_result(meter_reading_t got);
            meter_reading_t want;
            if (readings_due.size() == 0)
            begin
                faults++;
                if (faults <= MAX_REPORTS)
                    $display("%0t: reading for channel %0d with none outstanding",
                             $time, got.chan);
                return;
            end
            want = readings_due.pop_front();
            if (got.chan !== want.chan || got.hz !== want.hz || got.rpm !== want.rpm ||
                got.nosig !== want.nosig || got.ign !== want.ign)
            begin
                faults++;
                if (faults <= MAX_REPORTS)
                    $display({"%0t: expected ch %0d hz %0d rpm %0d nosig %0b ign %0b,",
                              " got ch %0d hz %0d rpm %0d nosig %0b ign %0b"},
                             $time, want.chan, want.hz, want.rpm, want.nosig, want.ign,
                             got.chan, got.hz, got.rpm, got.nosig, got.ign);
            end
        endfunction
    endclass

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    int                    tx_idle_pct = IDLE_PCT;
    int                    rx_idle_pct = IDLE_PCT;
    int                    reg_writes  = 0;
    meter_scoreboard       meters;

    pfm_evt_if evt_bus();
    pfm_res_if res_bus();

    pulse_frequency_meter_core #(
        .CHANNELS     (NUM_CH),
        .COUNTER_BITS (16)
    ) i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .evt       (evt_bus),
        .res       (res_bus),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    task automatic send_event(input logic [CMD_W-1:0] cmd, input logic [CH_W-1:0] ch,
                              input logic [SMP_IN_W-1:0] smp);
        while ($urandom_range(99) < tx_idle_pct)
        begin
            evt_bus.valid <= 1'b0;
            @(posedge clk);
        end
        evt_bus.valid   <= 1'b1;
        evt_bus.cmd     <= cmd;
        evt_bus.channel <= ch;
        evt_bus.sample  <= smp;
        @(posedge clk);
        while (!evt_bus.ready)
            @(posedge clk);
        meters.note_event(cmd, ch, smp);
    endtask

    task automatic wait_drained();
        do
            @(posedge clk);
        while (meters.readings_due.size() != 0);
    endtask

    task automatic settle();
        evt_bus.valid <= 1'b0;
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        meters.apply_register(idx, data);
        reg_writes++;
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    task automatic program_setup(input logic [CFG_DATA_W-1:0] mask, input logic [CFG_DATA_W-1:0] hz,
                                 input logic [CFG_DATA_W-1:0] cpw, input logic [CFG_DATA_W-1:0] gate,
                                 input logic [CFG_DATA_W-1:0] maxw);
        write_reg(CFG_MODE_MASK, mask);
        write_reg(CFG_CLOCK_HZ, hz);
        write_reg(CFG_CPW, cpw);
        write_reg(CFG_GATE_MS, gate);
        write_reg(CFG_MAX_WRAPS, maxw);
    endtask

    // mostly well-formed wrap/capture runs and gate bursts, some noise
    task automatic run_traffic(input int n_items, input bit pause_midway);
        int                  sent;
        int                  pick;
        int                  burst;
        logic [CH_W-1:0]     ch;
        logic [SMP_IN_W-1:0] smp;
        sent = 0;
        while (sent < n_items)
        begin
            if (pause_midway && sent >= n_items / 2)
            begin
                evt_bus.valid <= 1'b0;
                wait_drained();
                pause_midway = 1'b0;
            end
            pick = $urandom_range(99);
            if (pick < 10)
                send_event(CMD_W'($urandom_range(3)), CH_W'($urandom_range(7)),
                           SMP_IN_W'($urandom_range(65535)));
            else
            begin
                ch = CH_W'($urandom_range(NUM_CH - 1));
                if (meters.mode_mask[ch])
                begin
                    burst = $urandom_range(1, 8);
                    repeat (burst)
                    begin
                        pick = $urandom_range(99);
                        if (pick < 55)
                            smp = SMP_IN_W'($urandom_range(2));
                        else if (pick < 80)
                            smp = SMP_IN_W'($urandom_range(3, 200));
                        else
                            smp = SMP_IN_W'($urandom_range(65535));
                        send_event(CMD_GATE_END, ch, smp);
                    end
                    sent += burst;
                end
                else
                begin
                    burst = ($urandom_range(9) < 7) ? $urandom_range(3) : $urandom_range(12);
                    repeat (burst)
                        send_event(CMD_WRAP, ch, SMP_IN_W'($urandom_range(65535)));
                    pick = $urandom_range(99);
                    if (pick < 40)
                        smp = SMP_IN_W'($urandom_range(65535));
                    else if (pick < 70)
                        smp = SMP_IN_W'($urandom_range(15));
                    else
                        smp = SMP_IN_W'($urandom_range(2000));
                    send_event(CMD_CAPTURE, ch, smp);
                    sent += burst + 1;
                end
            end
        end
    endtask

    initial
    begin
        meter_reading_t got;
        res_bus.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && res_bus.valid && res_bus.ready)
            begin
                got.chan  = res_bus.out_channel;
                got.hz    = res_bus.freq_hz;
                got.rpm   = res_bus.per_minute;
                got.nosig = res_bus.no_signal;
                got.ign   = res_bus.ignored;
                meters.check_result(got);
            end
            res_bus.ready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    initial
    begin
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((evt_bus.valid && evt_bus.ready) || (res_bus.valid && res_bus.ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("no transfer for %0d cycles, %0d readings outstanding",
                 STALL_LIMIT, meters.readings_due.size());
        $display("[pulse_frequency_meter_core] ERROR");
        $finish;
    end

    initial
    begin
        meters = new();
        rst_n           <= 1'b0;
        evt_bus.valid   <= 1'b0;
        evt_bus.cmd     <= CMD_WRAP;
        evt_bus.channel <= '0;
        evt_bus.sample  <= '0;
        cfg_we          <= 1'b0;
        cfg_index       <= CFG_MODE_MASK;
        cfg_data        <= '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset defaults: all channels in period mode
        send_event(CMD_CAPTURE, 0, 16'd0);
        send_event(CMD_WRAP, 0, 16'hFFFF);
        send_event(CMD_CAPTURE, 0, 16'hFFFF);
        send_event(CMD_CAPTURE, 1, 16'd1);
        send_event(CMD_GATE_END, 2, 16'd5);
        send_event(CMD_UNUSED, 3, 16'h5A5A);
        send_event(CMD_WRAP, CH_W'(NUM_CH), 16'hFFFF);
        send_event(CMD_CAPTURE, CH_W'(NUM_CH + 1), 16'd0);
        settle();

        // gated low windows, zero clock, wrap count pinned at zero
        program_setup(30'h0F, 0, CFG_DATA_W'(CPW_RESET), 1, 0);
        send_event(CMD_GATE_END, 0, 16'd0);
        send_event(CMD_GATE_END, 0, 16'd2);
        send_event(CMD_GATE_END, 0, 16'd1);
        send_event(CMD_GATE_END, 0, 16'd3);
        send_event(CMD_GATE_END, 1, 16'hFFFF);
        send_event(CMD_WRAP, 2, 16'd0);
        send_event(CMD_CAPTURE, 3, 16'd100);
        send_event(CMD_WRAP, 4, 16'd0);
        send_event(CMD_CAPTURE, 5, 16'd7);
        settle();

        // zero gate length, wrap saturation, writes to spare indexes
        program_setup(30'h0F, 1000000000, 1, 0, 2);
        for (int i = CFG_SPARE_FIRST; i < 2 ** CFG_IDX_W; i++)
            write_reg(CFG_IDX_W'(i), CFG_DATA_W'($urandom));
        send_event(CMD_GATE_END, 0, 16'd1);
        repeat (3) send_event(CMD_WRAP, 4, 16'h8001);
        send_event(CMD_CAPTURE, 4, 16'd9);
        send_event(CMD_WRAP, 5, 16'h7FFE);
        settle();

        program_setup(30'h15, 1000000000, 1, 1, 1);
        run_traffic(220, 1'b0);
        settle();

        program_setup(30'h3F, 12000000, 1000, 60000, 3);
        run_traffic(220, 1'b1);
        settle();

        tx_idle_pct = 0;
        rx_idle_pct = 0;
        program_setup(30'h00, 1, 65536, 250, 65535);
        run_traffic(220, 1'b0);
        settle();
        tx_idle_pct = IDLE_PCT;
        rx_idle_pct = IDLE_PCT;

        program_setup(30'h2A, 0, 0, 0, 0);
        run_traffic(200, 1'b0);
        settle();

        // upper data bits beyond each register width must drop
        program_setup(30'h3FFF_FFCC, 999999999, 30'h3FFE_0064, 30'h3FFF_0014, 30'h3FFF_0005);
        for (int i = CFG_SPARE_FIRST; i < 2 ** CFG_IDX_W; i++)
            write_reg(CFG_IDX_W'(i), CFG_DATA_W'($urandom));
        run_traffic(220, 1'b0);
        settle();

        repeat (3)
        begin
            program_setup(CFG_DATA_W'($urandom_range(63)),
                          CFG_DATA_W'($urandom_range(1, 1000000000)),
                          CFG_DATA_W'($urandom_range(1, 65536)),
                          CFG_DATA_W'($urandom_range(1, 60000)),
                          CFG_DATA_W'($urandom_range(1, 8)));
            run_traffic(200, 1'b0);
            settle();
        end

        $display("covered %0d wraps, %0d captures, %0d gate ends, %0d ignored (%0d off-range)",
                 meters.n_wrap, meters.n_capture, meters.n_gate, meters.n_ignored,
                 meters.n_outside);
        $display("%0d no-signal and %0d clipped per-minute readings across %0d register writes",
                 meters.n_nosig, meters.n_clipped, reg_writes);
        if (meters.faults == 0 && meters.readings_due.size() == 0)
            $display("[pulse_frequency_meter_core] OK");
        else
        begin
            $display("%0d failures, %0d readings missing",
                     meters.faults, meters.readings_due.size());
            $display("[pulse_frequency_meter_core] ERROR");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
hdl/pfm_pkg.sv
hdl/pfm_evt_if.sv
hdl/pfm_res_if.sv
hdl/pfm_div.sv
hdl/pulse_frequency_meter_core.sv
tb/tb_top.sv
